[hdl/spm_pkg.sv]
// Shared types and constants for the sample playback mixer.
package spm_pkg;

  localparam int unsigned RateW = 17;
  localparam int unsigned PosW = 24;
  localparam int unsigned IdxW = 16;
  localparam int unsigned FracW = 8;
  localparam int unsigned DivQW = 24;
  localparam logic [RateW-1:0] RateReset = 17'd22050;
  localparam logic [FracW-1:0] FracMax = 8'hFF;
  localparam int signed MixMax = 127;

  typedef enum logic [2:0] {
    MODE_TICK = 3'd0,
    MODE_PLAY = 3'd1,
    MODE_STOP = 3'd2,
    MODE_VOL = 3'd3,
    MODE_STOP_ALL = 3'd4,
    MODE_WRITE = 3'd5,
    MODE_RESV_A = 3'd6,
    MODE_RESV_B = 3'd7
  } mode_t;

  typedef struct packed {
    logic start;
    logic [23:0] dividend;
    logic [RateW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DivQW-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/spm_divider.sv]
// Restoring divider, one quotient bit per cycle, for the channel step.
module spm_divider (
  input  logic             clk,
  input  logic             rst,
  input  spm_pkg::div_req_t req,
  output spm_pkg::div_rsp_t rsp
);
  import spm_pkg::*;

  logic [4:0] count;
  logic [RateW:0] rem;
  logic [DivQW-1:0] quo;
  logic [RateW-1:0] dvs;
  logic busy;
  logic done;
  logic [RateW:0] trial;

  always_comb begin
    trial = {rem[RateW-1:0], quo[DivQW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 5'(DivQW);
        rem <= '0;
        quo <= req.dividend;
        dvs <= (req.divisor == '0) ? RateW'(1) : req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[DivQW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[DivQW-2:0], 1'b0};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

[hdl/spm_sample_ram.sv]
// Sample byte memory with one write port and one registered read port.
module spm_sample_ram #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/sample_playback_mixer_top.sv]
// Top level of the four-channel sample playback mixer.
//  channel | signals                               | item
//  s_axis  | s_axis_tvalid/tready/tuser[2:0]/tdata | command
//  m_axis  | m_axis_tvalid/tready/tdata[15:0]      | mix result for a tick
//  apb     | psel/penable/pwrite/paddr/pwdata      | output_rate register
// A tick visits each channel in turn through one sample port and one
// multiply unit: S_CH, S_RD1, S_RD2, S_W1, S_W2 and S_MAC for an active
// channel, S_CH alone for an idle or ending one, then S_CH posts the result.
// Play waits in S_DIV on the serial step divider; other commands do not.
// Reset clears all channel state; sample memory is not cleared.
// A waiting result holds only the end of the next tick.
module sample_playback_mixer_top #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[2:0]
  input  logic [2:0]   s_axis_tuser,
  // channel[1:0] freq[17:2] volume[25:18] sample_start[41:26]
  // sample_length[57:42] loop_start[73:58] loop_length[89:74]
  // write_addr[105:90] write_byte[113:106], zero above
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mixed_sample[7:0] active_mask[11:8], zero above
  output logic [15:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import spm_pkg::*;

  localparam int unsigned ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CH, S_RD1, S_RD2, S_W1, S_W2, S_MAC, S_OUT
  } state_t;

  state_t state;
  logic [RateW-1:0] output_rate;
  logic [NUM_CHANNELS-1:0] act;
  logic [7:0] vol [NUM_CHANNELS];
  logic [PosW-1:0] pos [NUM_CHANNELS];
  logic [PosW-1:0] step [NUM_CHANNELS];
  logic [IdxW-1:0] base [NUM_CHANNELS];
  logic [IdxW-1:0] len [NUM_CHANNELS];
  logic [IdxW-1:0] lps [NUM_CHANNELS];
  logic [IdxW-1:0] lpl [NUM_CHANNELS];

  logic [2:0] mode;
  logic [1:0] chan_in;
  logic [ChW-1:0] pch;
  logic [ChW:0] ci;
  logic [ChW-1:0] cix;
  logic [IdxW-1:0] p2;
  logic [IdxW-1:0] p1r;
  logic [FracW-1:0] ilc;
  logic signed [7:0] b1;
  logic signed [16:0] acc;
  logic signed [9:0] mix;
  logic [1:0] mac_ph;
  logic [15:0] out_data;
  logic out_valid;
  logic post;

  div_req_t dreq;
  div_rsp_t drsp;
  logic ram_we;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;

  assign mode = s_axis_tuser;
  assign chan_in = s_axis_tdata[1:0];
  assign cix = ci[ChW-1:0];

  assign pready = 1'b1;
  assign prdata = {{(32-RateW){1'b0}}, output_rate};

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;
  assign post = (state == S_CH) && (32'(ci) >= NUM_CHANNELS) &&
                (!out_valid || m_axis_tready);

  assign ram_we = s_axis_tvalid && s_axis_tready && (mode == MODE_WRITE);

  assign dreq.start = s_axis_tvalid && s_axis_tready && (mode == MODE_PLAY) &&
                      (32'(chan_in) < NUM_CHANNELS);
  assign dreq.dividend = {s_axis_tdata[17:2], 8'd0};
  assign dreq.divisor = output_rate;

  spm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  spm_sample_ram #(.DEPTH(SAMPLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(s_axis_tdata[90+AW-1:90]),
    .wdata(s_axis_tdata[113:106]), .raddr(raddr), .rdata(rdata)
  );

  logic [IdxW-1:0] p1;
  logic [IdxW:0] loop_end;
  logic [IdxW:0] p1n;
  logic signed [10:0] mix_sum;
  logic signed [16:0] mul_a;
  logic signed [8:0] mul_b;
  logic signed [25:0] prod;
  logic signed [25:0] sc_raw;
  logic signed [17:0] scaled;

  always_comb begin
    p1 = pos[cix][PosW-1:FracW];
    loop_end = {1'b0, lps[cix]} + {1'b0, lpl[cix]} - 17'd1;
    p1n = {1'b0, p1} + 17'd1;
    raddr = AW'((state == S_RD1) ? base[cix] + p1r : base[cix] + p2);
    unique case (mac_ph)
      2'd0: begin
        mul_a = 17'(b1);
        mul_b = $signed({1'b0, FracMax - ilc});
      end
      2'd1: begin
        mul_a = 17'($signed(rdata));
        mul_b = $signed({1'b0, ilc});
      end
      default: begin
        mul_a = acc;
        mul_b = $signed({1'b0, vol[cix]});
      end
    endcase
    prod = mul_a * mul_b;
    sc_raw = prod;
    scaled = 18'((sc_raw < 0) ? -((-sc_raw) >>> 6) : (sc_raw >>> 6));
    mix_sum = 11'(mix) + 11'(scaled > 18'sd255 ? 18'sd255 :
              (scaled < -18'sd255 ? -18'sd255 : scaled));
  end

  function automatic logic signed [16:0] bq_next(input logic signed [16:0] a,
                                                input logic signed [25:0] p);
    logic signed [17:0] s;
    s = 18'(a) + 18'(p);
    return 17'(s >>> 8);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      output_rate <= RateReset;
      act <= '0;
      out_valid <= 1'b0;
      mac_ph <= '0;
      ci <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vol[i] <= '0; pos[i] <= '0; step[i] <= '0; base[i] <= '0;
        len[i] <= '0; lps[i] <= '0; lpl[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) begin
        output_rate <= pwdata[RateW-1:0];
      end
      if (post) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            priority if (mode == MODE_TICK) begin
              ci <= '0;
              mix <= '0;
              state <= S_CH;
            end else if (mode == MODE_PLAY) begin
              if (32'(chan_in) < NUM_CHANNELS) begin
                pch <= ChW'(chan_in);
                act[ChW'(chan_in)] <= 1'b1;
                vol[ChW'(chan_in)] <= s_axis_tdata[25:18];
                base[ChW'(chan_in)] <= s_axis_tdata[41:26];
                len[ChW'(chan_in)] <= s_axis_tdata[57:42];
                lps[ChW'(chan_in)] <= s_axis_tdata[73:58];
                lpl[ChW'(chan_in)] <= s_axis_tdata[89:74];
                pos[ChW'(chan_in)] <= '0;
                state <= S_DIV;
              end
            end else if (mode == MODE_STOP) begin
              if (32'(chan_in) < NUM_CHANNELS) act[ChW'(chan_in)] <= 1'b0;
            end else if (mode == MODE_VOL) begin
              if (32'(chan_in) < NUM_CHANNELS) vol[ChW'(chan_in)] <= s_axis_tdata[25:18];
            end else if (mode == MODE_STOP_ALL) begin
              act <= '0;
            end else begin
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            step[pch] <= drsp.quotient;
            state <= S_IDLE;
          end
        end
        S_CH: begin
          if (32'(ci) >= NUM_CHANNELS) begin
            if (post) begin
              out_data <= {4'd0, 4'(act), mix[7:0]};
              state <= S_IDLE;
            end
          end else if (!act[cix]) begin
            ci <= ci + 1'b1;
          end else begin
            ilc <= pos[cix][FracW-1:0];
            p1r <= p1;
            if (lpl[cix] != '0) begin
              if ({1'b0, p1} >= loop_end) begin
                p2 <= lps[cix];
                pos[cix] <= {lps[cix], 8'd0};
              end else begin
                p2 <= p1n[IdxW-1:0];
                pos[cix] <= pos[cix] + step[cix];
              end
              state <= S_RD1;
            end else begin
              pos[cix] <= pos[cix] + step[cix];
              if (p1n >= {1'b0, len[cix]}) begin
                act[cix] <= 1'b0;
                ci <= ci + 1'b1;
              end else begin
                p2 <= p1n[IdxW-1:0];
                state <= S_RD1;
              end
            end
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          b1 <= $signed(rdata);
          state <= S_W1;
        end
        S_W1: begin
          mac_ph <= 2'd0;
          state <= S_W2;
        end
        S_W2: begin
          acc <= 17'(prod);
          mac_ph <= 2'd1;
          state <= S_MAC;
        end
        S_MAC: begin
          if (mac_ph == 2'd1) begin
            acc <= bq_next(acc, prod);
            mac_ph <= 2'd2;
          end else begin
            mix <= (mix_sum > 11'sd127) ? 10'sd127 :
                   ((mix_sum < -11'sd127) ? -10'sd127 : 10'(mix_sum));
            ci <= ci + 1'b1;
            state <= S_CH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{s_axis_tdata[119:114], pwdata[31:RateW], drsp.busy,
                    MixMax[0]};
endmodule

[hdl/spm_checker.sv]
// Port-level checks for the sample playback mixer, bound to the top level.
module spm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80)
    else $error("mix out of range");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
    else $error("pad bits set");
endmodule

bind sample_playback_mixer_top spm_checker u_spm_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);
